### hdl/fdr_pkg.sv
// Package for the flip-dot row command encoder: item types, command
// constants and the command builder. No dependencies.
`default_nettype none
package fdr_pkg;

	localparam int CMD_BITS = 41;
	localparam int CNT_W    = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam int Q_DEPTH  = 2;
	localparam int Q_AW     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PANELS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF   = 1'd1;

	localparam logic [4:0] PULSE_ONE  = 5'd20;
	localparam logic [4:0] PULSE_ZERO = 5'd5;

	typedef struct packed {
		logic [2:0]  panel_col;
		logic [4:0]  frame_row;
		logic [11:0] pixels;
		logic        frame_end;
	} in_item_t;

	typedef struct packed {
		logic       line_bit;
		logic [4:0] pulse_us;
		logic       last_bit;
	} out_item_t;

	typedef logic [CMD_BITS-1:0] cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] column_byte(input logic [3:0] n);
		return {n[0], ~n[0], n[1], ~n[1], n[2], ~n[2], n[3], ~n[3]};
	endfunction

	function automatic cmd_t build_cmd(input logic [7:0] addr, input logic [4:0] y,
		input logic [11:0] pix);
		return {1'b1, ~addr, {y[2:0], 5'b0}, column_byte(pix[11:8]),
			column_byte(pix[7:4]), column_byte(pix[3:0])};
	endfunction

endpackage
`default_nettype wire

### hdl/flipdot_row_diff_command_encoder_unit.sv
// Top level of the flip-dot row command encoder: front end, command queue
// and serializer. Uses fdr_pkg, fdr_front, fdr_queue and fdr_back.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_we               | cfg_idx, cfg_data
//   in      | in        | in_valid / in_ready  | in_item (in_item_t)
//   out     | out       | out_valid / out_ready| out_item (out_item_t)
//
// A row that is sent yields 41 result items, one per cycle from the serializer
// output register while out_ready holds; a skipped row is dropped in the front end.
// Rows enter back to back; the two-entry queue lets the front end run ahead.
// After reset the sent-row store is cleared, one entry a cycle, through all
// MAX_PANEL_COLS*MAX_ROWS entries (256 by default); no item is taken meanwhile.
// Out stalls hold the serializer; in_ready drops while a row waits in the
// front end on a full queue.
`default_nettype none
module flipdot_row_diff_command_encoder_unit #(
	parameter int MAX_PANEL_COLS = 8,
	parameter int MAX_ROWS       = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [fdr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire fdr_pkg::in_item_t              in_item,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output fdr_pkg::out_item_t                  out_item
);
	import fdr_pkg::*;

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    pop_cmd;

	fdr_front #(
		.MAX_PANEL_COLS (MAX_PANEL_COLS),
		.MAX_ROWS       (MAX_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	fdr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	fdr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

### hdl/fdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fdr_ram #(
	parameter int W     = 12,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/fdr_front.sv
// Front end: accepts row items, checks them against the sent-row store and
// pushes commands for rows to send. Uses fdr_pkg and fdr_ram.
`default_nettype none
module fdr_front #(
	parameter int MAX_PANEL_COLS = 8,
	parameter int MAX_ROWS       = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fdr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [fdr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire fdr_pkg::in_item_t                in_item,
	input  wire fdr_pkg::q_stat_t                 q_stat,
	output logic                                  push,
	output fdr_pkg::cmd_t                         push_cmd
);
	import fdr_pkg::*;

	localparam int DEPTH = MAX_PANEL_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	logic [2:0]    panels_q;
	logic          diff_q;
	logic          pend_q;
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	logic          s1_vld;
	in_item_t      s1_item;
	logic [AW-1:0] s1_idx;
	logic          s1_in_store;

	logic          fwd_vld_q;
	logic [AW-1:0] fwd_idx_q;
	logic [11:0]   fwd_pix_q;

	logic          accept;
	logic          s1_fire;
	logic          in_store;
	logic [AW-1:0] idx;
	logic [11:0]   rd_data;
	logic [11:0]   stored;
	logic          send;
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [11:0]   st_wdata;
	logic [7:0]    addr;

	assign in_store = (32'(in_item.panel_col) < MAX_PANEL_COLS) &&
		(32'(in_item.frame_row) < MAX_ROWS);
	assign idx = AW'(32'(in_item.panel_col) * MAX_ROWS + 32'(in_item.frame_row));

	assign s1_fire  = s1_vld && !q_stat.full;
	assign in_ready = !clr_q && (!s1_vld || s1_fire);
	assign accept   = in_valid && in_ready;

	assign stored = (fwd_vld_q && fwd_idx_q == s1_idx) ? fwd_pix_q : rd_data;
	assign send   = !diff_q || pend_q || !s1_in_store || (stored != s1_item.pixels);

	assign addr = 8'({5'b0, s1_item.panel_col} * {5'b0, panels_q}) +
		8'(s1_item.frame_row[4:3]) + 8'd1;

	assign push     = s1_fire && send;
	assign push_cmd = build_cmd(addr, s1_item.frame_row, s1_item.pixels);

	assign st_we    = clr_q || (s1_fire && send && s1_in_store);
	assign st_waddr = clr_q ? clr_idx_q : s1_idx;
	assign st_wdata = clr_q ? 12'd0 : s1_item.pixels;

	fdr_ram #(.W(12), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (accept),
		.raddr (idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panels_q  <= 3'd1;
			diff_q    <= 1'b1;
			pend_q    <= 1'b1;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			s1_vld    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PANELS: panels_q <= cfg_data[2:0];
					REG_DIFF:   diff_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				s1_vld <= 1'b1;
			end else if (s1_fire) begin
				s1_vld <= 1'b0;
			end
			if (s1_fire) begin
				if (s1_item.frame_end) begin
					pend_q <= 1'b0;
				end
				if (send && s1_in_store) begin
					fwd_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item     <= in_item;
			s1_idx      <= idx;
			s1_in_store <= in_store;
		end
		if (s1_fire && send && s1_in_store) begin
			fwd_idx_q <= s1_idx;
			fwd_pix_q <= s1_item.pixels;
		end
	end

endmodule
`default_nettype wire

### hdl/fdr_queue.sv
// Short command queue between the front end and the serializer.
// Uses fdr_pkg.
`default_nettype none
module fdr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fdr_pkg::cmd_t  push_cmd,
	input  wire logic           pop,
	output fdr_pkg::cmd_t       pop_cmd,
	output fdr_pkg::q_stat_t    stat
);
	import fdr_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign stat.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_cmd    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

### hdl/fdr_back.sv
// Back end: shifts each queued command out one bit per result item.
// Uses fdr_pkg.
`default_nettype none
module fdr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fdr_pkg::q_stat_t q_stat,
	input  wire fdr_pkg::cmd_t    pop_cmd,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output fdr_pkg::out_item_t    out_item
);
	import fdr_pkg::*;

	logic             busy_q;
	cmd_t             vec_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_vld_q;
	out_item_t        out_q;
	logic             adv;

	assign adv       = !out_vld_q || out_ready;
	assign pop       = adv && !busy_q && !q_stat.empty;
	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				out_vld_q <= 1'b1;
				cnt_q     <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CMD_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end else if (!q_stat.empty) begin
				out_vld_q <= 1'b1;
				cnt_q     <= CNT_W'(1);
				busy_q    <= 1'b1;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				out_q.line_bit <= vec_q[CMD_BITS-1];
				out_q.pulse_us <= vec_q[CMD_BITS-1] ? PULSE_ONE : PULSE_ZERO;
				out_q.last_bit <= (cnt_q == CNT_W'(CMD_BITS - 1));
				vec_q          <= vec_q << 1;
			end else if (!q_stat.empty) begin
				out_q.line_bit <= pop_cmd[CMD_BITS-1];
				out_q.pulse_us <= pop_cmd[CMD_BITS-1] ? PULSE_ONE : PULSE_ZERO;
				out_q.last_bit <= 1'b0;
				vec_q          <= pop_cmd << 1;
			end
		end
	end

endmodule
`default_nettype wire

### dv/flipdot_row_diff_command_encoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the flip-dot row command encoder: random and directed
// rows, bursty sender, stalling receiver, per-bit command checks.
// Depends on fdr_pkg and flipdot_row_diff_command_encoder_unit.
module flipdot_row_diff_command_encoder_unit_test;
	import fdr_pkg::*;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;

	flipdot_row_diff_command_encoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	in_item_t    pending_rows[$];
	out_item_t   expected_bits[$];
	logic [11:0] row_store [256];
	logic [11:0] gen_last_pix [256];
	logic        refresh_pending;
	logic [2:0]  cfg_panels;
	logic        cfg_diff;

	logic     in_fired;
	int       send_gap;
	int       burst_left;
	rx_mode_e rx_mode;
	int       rx_left;
	int       rx_tick;
	int       errors;
	int       rows_seen;
	int       rows_sent;
	int       bits_checked;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d command bits outstanding", expected_bits.size());
		$display("TB_ERROR");
		$finish;
	end

	task automatic encode_row(input in_item_t it);
		logic [7:0]  idx;
		int          base;
		logic [7:0]  addr;
		logic [7:0]  cb [3];
		logic [40:0] cmd;
		out_item_t   ob;
		idx = {it.panel_col, it.frame_row};
		rows_seen++;
		if (!cfg_diff || refresh_pending || row_store[idx] != it.pixels) begin
			addr = 8'(1 + it.panel_col * cfg_panels + it.frame_row[4:3]);
			for (int g = 0; g < 3; g++) begin
				cb[g] = 8'h00;
				base = 8 - 4 * g;
				for (int k = 0; k < 4; k++) begin
					if (it.pixels[base + k])
						cb[g][7 - 2 * k] = 1'b1;
					else
						cb[g][6 - 2 * k] = 1'b1;
				end
			end
			cmd = {1'b1, ~addr, it.frame_row[2:0], 5'b0, cb[0], cb[1], cb[2]};
			for (int i = 40; i >= 0; i--) begin
				ob.line_bit = cmd[i];
				ob.pulse_us = cmd[i] ? PULSE_ONE : PULSE_ZERO;
				ob.last_bit = (i == 0);
				expected_bits.push_back(ob);
			end
			row_store[idx] = it.pixels;
			rows_sent++;
		end
		if (it.frame_end)
			refresh_pending = 1'b0;
	endtask

	// accept rows into the predictor, then check command bits
	always @(posedge clk) begin
		out_item_t want;
		in_fired <= in_valid && in_ready;
		if (in_valid && in_ready)
			encode_row(in_item);
		if (out_valid && out_ready) begin
			if (expected_bits.size() == 0) begin
				errors++;
				if (errors <= 100)
					$display("%0t unexpected command bit: line %0b pulse %0d last %0b",
						$time, out_item.line_bit, out_item.pulse_us, out_item.last_bit);
			end else begin
				want = expected_bits.pop_front();
				bits_checked++;
				if (out_item.line_bit !== want.line_bit || out_item.pulse_us !== want.pulse_us ||
						out_item.last_bit !== want.last_bit) begin
					errors++;
					if (errors <= 100)
						$display("%0t mismatch: expected line %0b pulse %0d last %0b, %s %0b %0d %0b",
							$time, want.line_bit, want.pulse_us, want.last_bit,
							"got line/pulse/last", out_item.line_bit, out_item.pulse_us,
							out_item.last_bit);
				end
			end
		end
	end

	// sender: hold until taken, advance in bursts with random gaps
	always @(negedge clk) begin
		if (!in_valid || in_fired) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_rows.size() != 0) begin
				in_item <= pending_rows.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches to a random mode at random intervals
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(32, 400);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:    out_ready <= 1'b1;
			RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
			RX_PATTERN: out_ready <= (rx_tick % 7) < 4;
			default:    out_ready <= 1'b1;
		endcase
	end

	task automatic add_row(input logic [2:0] col, input logic [4:0] row,
		input logic [11:0] pix, input logic fend);
		in_item_t it;
		it.panel_col = col;
		it.frame_row = row;
		it.pixels    = pix;
		it.frame_end = fend;
		pending_rows.push_back(it);
		gen_last_pix[{col, row}] = pix;
	endtask

	// mostly a small working window with repeated or near-repeated rows
	task automatic queue_random_rows(input int n);
		logic [2:0]  col;
		logic [4:0]  row;
		logic [11:0] pix;
		int          pick;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				col = 3'($urandom_range(0, 1));
				row = 5'($urandom_range(0, 7));
			end else begin
				col = 3'($urandom_range(0, 7));
				row = 5'($urandom_range(0, 31));
			end
			pick = $urandom_range(0, 9);
			if (pick < 4)
				pix = gen_last_pix[{col, row}];
			else if (pick < 6)
				pix = gen_last_pix[{col, row}] ^ (12'h1 << $urandom_range(0, 11));
			else
				pix = 12'($urandom_range(0, 4095));
			add_row(col, row, pix, $urandom_range(0, 11) == 0);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		if (idx == REG_PANELS)
			cfg_panels = val;
		else
			cfg_diff = val[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_rows.size() != 0 || in_valid || expected_bits.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		in_item    = '0;
		out_ready  = 1'b0;
		in_fired   = 1'b0;
		send_gap   = 0;
		burst_left = 0;
		rx_mode    = RX_OPEN;
		rx_left    = 0;
		rx_tick    = 0;
		errors     = 0;
		rows_seen  = 0;
		rows_sent  = 0;
		bits_checked = 0;
		for (int i = 0; i < 256; i++) begin
			row_store[i]    = 12'h000;
			gen_last_pix[i] = 12'h000;
		end
		refresh_pending = 1'b1;
		cfg_panels      = 3'd1;
		cfg_diff        = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first frame goes out whole, even rows equal to the cleared store
		add_row(3'd0, 5'd0,  12'h000, 1'b0);
		add_row(3'd7, 5'd31, 12'hFFF, 1'b0);
		add_row(3'd3, 5'd8,  12'hA5A, 1'b0);
		add_row(3'd5, 5'd17, 12'h5A5, 1'b0);
		add_row(3'd7, 5'd0,  12'h800, 1'b0);
		add_row(3'd0, 5'd31, 12'h001, 1'b0);
		add_row(3'd2, 5'd15, 12'hFFF, 1'b1);
		// unchanged rows drop, changed rows go out
		add_row(3'd0, 5'd0,  12'h000, 1'b0);
		add_row(3'd7, 5'd31, 12'hFFF, 1'b0);
		add_row(3'd7, 5'd31, 12'hFFE, 1'b0);
		add_row(3'd3, 5'd8,  12'hA5A, 1'b1);
		add_row(3'd1, 5'd5,  12'h000, 1'b0);
		add_row(3'd1, 5'd5,  12'hFFF, 1'b0);
		wait_drained();

		write_reg(REG_PANELS, 3'd4);
		write_reg(REG_DIFF, 3'd0);
		add_row(3'd7, 5'd31, 12'hFFE, 1'b0);
		add_row(3'd0, 5'd0,  12'h000, 1'b1);
		add_row(3'd7, 5'd24, 12'h0F0, 1'b0);
		queue_random_rows(90);
		wait_drained();

		write_reg(REG_DIFF, 3'd1);
		queue_random_rows(110);
		wait_drained();

		write_reg(REG_PANELS, 3'd2);
		queue_random_rows(90);
		wait_drained();

		write_reg(REG_PANELS, 3'd1);
		write_reg(REG_DIFF, 3'd0);
		queue_random_rows(60);
		wait_drained();

		write_reg(REG_PANELS, 3'd3);
		write_reg(REG_DIFF, 3'd1);
		queue_random_rows(70);
		wait_drained();
		repeat (64) @(posedge clk);

		$display("Covered %0d rows over six register settings: %0d sent, %0d dropped as unchanged",
			rows_seen, rows_sent, rows_seen - rows_sent);
		$display("Checked %0d command bits, %0d failures", bits_checked, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/fdr_pkg.sv
hdl/fdr_ram.sv
hdl/fdr_front.sv
hdl/fdr_queue.sv
hdl/fdr_back.sv
hdl/flipdot_row_diff_command_encoder_unit.sv
dv/flipdot_row_diff_command_encoder_unit_test.sv
